/* rtl/packed_adc_bank_unpacker_assert.svh */
// Assertion macros used by the bank unpacker's unpack module.
`ifndef PACKED_ADC_BANK_UNPACKER_ASSERT_SVH
`define PACKED_ADC_BANK_UNPACKER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PABU_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pabu: check failed");

// The condition must hold in the cycle after the trigger.
`define PABU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pabu: check failed");

`endif

/* rtl/pabu_pkg.sv */
// Types, constants and helper functions for the packed ADC bank unpacker.
package pabu_pkg;

  localparam int WORD_W  = 32;
  localparam int BW_W    = 14;
  localparam int EID_W   = 12;
  localparam int TAG_W   = 32;
  localparam int CH_W    = 4;
  localparam int IDX_W   = 11;
  localparam int SMP_W   = 12;
  localparam int POS_W   = 14;
  localparam int SIB_W   = 5;
  localparam int LB_W    = 8;
  localparam int LC_W    = 4;
  localparam int ACC_W   = 48;

  localparam int MAX_BLOCKS   = 1024;
  localparam int BLOCK_W      = $clog2(MAX_BLOCKS + 1);
  localparam int HEADER_WORDS = 4;
  localparam int BLOCK_SAMPLES = 24;

  // Quotient of a 14-bit value by nine, by reciprocal multiplication.
  localparam int Q_W        = 11;
  localparam int DIV9_SHIFT = 17;
  localparam logic [14:0] DIV9_MULT = 15'd14564;

  localparam logic [POS_W-1:0] POS_LIMIT    = '1;
  localparam logic [POS_W-1:0] POS_EVENT_ID = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TIME_TAG = POS_W'(3);
  localparam logic [POS_W-1:0] POS_DATA     = POS_W'(HEADER_WORDS);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [EID_W-1:0]   event_id;
    logic [TAG_W-1:0]   time_tag;
    logic               size_warning;
    logic [CH_W-1:0]    channel;
    logic [IDX_W-1:0]   sample_index;
    logic [SMP_W-1:0]   sample;
    logic               last;
  } res_t;

  // One bank word with its size decoded, as handed to the unpack stage.
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               first_word;
    logic [BLOCK_W-1:0] blocks;
    logic               size_warning;
    logic               header_ok;
  } stage_t;

  // Sample position within a block divided by three (channel within the group).
  function automatic logic [2:0] sib_div3(input logic [SIB_W-1:0] s);
    logic [2:0] d;
    d = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (32'(s) >= 3 * k) d = 3'(k);
    end
    return d;
  endfunction

  // Remainder of the same division.
  function automatic logic [1:0] sib_mod3(input logic [SIB_W-1:0] s);
    logic [2:0]       d;
    logic [SIB_W-1:0] r;
    d = sib_div3(s);
    r = s - ({2'b00, d} + {1'b0, d, 1'b0});
    return r[1:0];
  endfunction

endpackage

/* rtl/pabu_if.sv */
// Valid/ready channels for bank words in and unpacked results out.
interface pabu_in_if import pabu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic [BW_W-1:0]   bank_words;
  logic              first_word;

  modport source (output valid, output word, output bank_words, output first_word,
                  input ready);
  modport sink (input valid, input word, input bank_words, input first_word,
                output ready);
endinterface

interface pabu_out_if import pabu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [EID_W-1:0] event_id;
  logic [TAG_W-1:0] time_tag;
  logic             size_warning;
  logic [CH_W-1:0]  channel;
  logic [IDX_W-1:0] sample_index;
  logic [SMP_W-1:0] sample;
  logic             last;

  modport source (output valid, output kind, output event_id, output time_tag,
                  output size_warning, output channel, output sample_index,
                  output sample, output last, input ready);
  modport sink (input valid, input kind, input event_id, input time_tag,
                input size_warning, input channel, input sample_index,
                input sample, input last, output ready);
endinterface

/* rtl/packed_adc_bank_unpacker.sv */
// Packed ADC bank unpacker: bank words in, header and 12-bit sample results out.
// Bank words enter an input register, pass a size-decode register (bank length
// less four, divided by nine) and reach the unpack stage, which tracks the bank
// and writes all results of one word at once into a three-entry result buffer.
// A new word can be taken every cycle unless the unpack stage stalls; the result
// port delivers one result per cycle while ready, so a data word gives two or three
// results (eight samples per three data words), the time-tag header word one, and
// the other header words and ignored words none. A word's first result appears once
// it has passed the input and size-decode registers into the result buffer. The
// single output port of the result buffer sets the sustained rate.
module packed_adc_bank_unpacker import pabu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pabu_in_if.sink     bank,
  pabu_out_if.source  result
);

  logic              a_valid;
  logic [WORD_W-1:0] a_word;
  logic [BW_W-1:0]   a_bw;
  logic              a_first;

  logic   b_valid;
  stage_t b_item;
  stage_t a_next;
  logic   u_ready;
  logic   b_free, a_adv, accept;

  logic             ge4;
  logic [BW_W-1:0]  d;
  logic [28:0]      prod;
  logic [Q_W-1:0]   q;
  logic [BW_W-1:0]  nine_q;
  logic [BW_W-1:0]  rem;

  assign b_free     = !b_valid || u_ready;
  assign a_adv      = a_valid && b_free;
  assign bank.ready = !a_valid || a_adv;
  assign accept     = bank.valid && bank.ready;

  // The quotient by nine is exact for every 14-bit length.
  assign ge4    = a_bw >= BW_W'(HEADER_WORDS);
  assign d      = a_bw - BW_W'(HEADER_WORDS);
  assign prod   = 29'(d) * 29'(DIV9_MULT);
  assign q      = prod[DIV9_SHIFT +: Q_W];
  assign nine_q = BW_W'({q, 3'b000}) + BW_W'(q);
  assign rem    = d - nine_q;

  always_comb begin
    a_next.word         = a_word;
    a_next.first_word   = a_first;
    a_next.header_ok    = ge4;
    a_next.size_warning = ge4 && (rem != '0);
    if (!ge4) begin
      a_next.blocks = '0;
    end else if (32'(q) > 32'(MAX_BLOCKS)) begin
      a_next.blocks = BLOCK_W'(MAX_BLOCKS);
    end else begin
      a_next.blocks = BLOCK_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (u_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_word  <= bank.word;
      a_bw    <= bank.bank_words;
      a_first <= bank.first_word;
    end
    if (a_adv) b_item <= a_next;
  end

  pabu_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (u_ready),
    .item       (b_item),
    .result     (result)
  );

endmodule

/* rtl/pabu_unpack.sv */
// Bank state tracking, 12-bit sample extraction and the result buffer.
`include "packed_adc_bank_unpacker_assert.svh"

module pabu_unpack import pabu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  stage_t            item,
  pabu_out_if.source        result
);

  logic [POS_W-1:0]   word_position, word_position_next;
  logic [BLOCK_W-1:0] block_count, block_count_next;
  logic [BLOCK_W-1:0] block_number, block_number_next;
  logic [SIB_W-1:0]   sample_in_block, sample_in_block_next;
  logic [LB_W-1:0]    leftover_bits, leftover_bits_next;
  logic [LC_W-1:0]    leftover_count, leftover_count_next;
  logic [EID_W-1:0]   saved_event_id, saved_event_id_next;

  res_t       slot [3];
  res_t       res_new [3];
  res_t       lane [3];
  res_t       cur;
  logic [1:0] cnt, cnt_new;
  logic [1:0] ptr;

  logic               take, finishing, load;
  logic [BLOCK_W-1:0] half, bib;
  logic               grp;
  logic [ACC_W-1:0]   acc;
  logic [5:0]         total;
  logic [1:0]         ns;
  logic [SIB_W-1:0]   sib_sum;
  logic [SIB_W-1:0]   lane_sib [3];
  logic [31:0]        lane_idx [3];

  assign take       = result.valid && result.ready;
  assign finishing  = take && (ptr == cnt - 2'd1);
  assign item_ready = (cnt == 2'd0) || finishing;
  assign load       = item_valid && item_ready;

  // The sample blocks are split into two channel groups by block number.
  assign half = block_count >> 1;
  assign grp  = block_number >= half;
  assign bib  = grp ? block_number - half : block_number;

  assign acc   = ({16'b0, item.word} << leftover_count) | {40'b0, leftover_bits};
  assign total = 6'd32 + 6'(leftover_count);
  assign ns    = (total >= 6'd36) ? 2'd3 : 2'd2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_sib[i] = sample_in_block + SIB_W'(i);
      lane_idx[i] = 32'(bib) * 32'd3 + 32'(sib_mod3(lane_sib[i]));
      lane[i] = '{kind: KIND_SAMPLE,
                  event_id: saved_event_id,
                  time_tag: '0,
                  size_warning: 1'b0,
                  channel: {grp, sib_div3(lane_sib[i])},
                  sample_index: lane_idx[i][IDX_W-1:0],
                  sample: acc[12*i +: SMP_W],
                  last: (2'(i) == ns - 2'd1)};
    end
  end

  always_comb begin
    word_position_next   = word_position;
    block_count_next     = block_count;
    block_number_next    = block_number;
    sample_in_block_next = sample_in_block;
    leftover_bits_next   = leftover_bits;
    leftover_count_next  = leftover_count;
    saved_event_id_next  = saved_event_id;
    cnt_new              = 2'd0;
    res_new              = lane;
    sib_sum              = sample_in_block + SIB_W'(ns);
    if (load) begin
      if (item.first_word) begin
        // A new bank restarts everything; its first word is header word 0.
        word_position_next   = POS_W'(1);
        block_count_next     = item.blocks;
        block_number_next    = '0;
        sample_in_block_next = '0;
        leftover_bits_next   = '0;
        leftover_count_next  = '0;
        saved_event_id_next  = '0;
      end else begin
        if (word_position != POS_LIMIT) word_position_next = word_position + POS_W'(1);
        if (word_position == POS_EVENT_ID) begin
          saved_event_id_next = item.word[EID_W-1:0];
        end else if (word_position == POS_TIME_TAG) begin
          if (item.header_ok) begin
            cnt_new    = 2'd1;
            res_new[0] = '{kind: KIND_HEADER,
                           event_id: saved_event_id,
                           time_tag: item.word,
                           size_warning: item.size_warning,
                           channel: '0,
                           sample_index: '0,
                           sample: '0,
                           last: 1'b1};
          end
        end else if (word_position >= POS_DATA && word_position != POS_LIMIT &&
                     block_number < block_count) begin
          cnt_new             = ns;
          leftover_count_next = LC_W'(total - 6'(ns) * 6'd12);
          leftover_bits_next  = (ns == 2'd2) ? acc[31:24] : acc[43:36];
          if (sib_sum >= SIB_W'(BLOCK_SAMPLES)) begin
            sample_in_block_next = '0;
            block_number_next    = block_number + BLOCK_W'(1);
          end else begin
            sample_in_block_next = sib_sum;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position   <= '0;
      block_count     <= '0;
      block_number    <= '0;
      sample_in_block <= '0;
      leftover_bits   <= '0;
      leftover_count  <= '0;
      saved_event_id  <= '0;
      cnt             <= 2'd0;
      ptr             <= 2'd0;
    end else begin
      word_position   <= word_position_next;
      block_count     <= block_count_next;
      block_number    <= block_number_next;
      sample_in_block <= sample_in_block_next;
      leftover_bits   <= leftover_bits_next;
      leftover_count  <= leftover_count_next;
      saved_event_id  <= saved_event_id_next;
      if (load) begin
        cnt <= cnt_new;
        ptr <= 2'd0;
      end else if (finishing) begin
        cnt <= 2'd0;
        ptr <= 2'd0;
      end else if (take) begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot <= res_new;
  end

  assign cur                 = slot[ptr];
  assign result.valid        = cnt != 2'd0;
  assign result.kind         = cur.kind;
  assign result.event_id     = cur.event_id;
  assign result.time_tag     = cur.time_tag;
  assign result.size_warning = cur.size_warning;
  assign result.channel      = cur.channel;
  assign result.sample_index = cur.sample_index;
  assign result.sample       = cur.sample;
  assign result.last         = cur.last;

  `PABU_ASSERT_NOW(a_leftover_legal, 1'b1, leftover_count == 4'd0 || leftover_count == 4'd4 || leftover_count == 4'd8)
  `PABU_ASSERT_NOW(a_sib_range, 1'b1, sample_in_block < SIB_W'(BLOCK_SAMPLES))
  `PABU_ASSERT_NOW(a_block_bound, 1'b1, block_number <= block_count)
  `PABU_ASSERT_NOW(a_last_at_end, result.valid, result.last == (ptr == cnt - 2'd1))
  `PABU_ASSERT_NEXT(a_ptr_advance, result.valid && result.ready && !result.last, ptr == $past(ptr) + 2'd1)

endmodule

/* tb/sv/packed_adc_bank_unpacker_tb.sv */
// Self-checking testbench for the packed ADC bank unpacker, with its own unpacking predictor.
module packed_adc_bank_unpacker_tb;
  import pabu_pkg::*;

  typedef struct packed {
    bit                wait_drain;
    bit                fast;
    logic              first_word;
    logic [BW_W-1:0]   bank_words;
    logic [WORD_W-1:0] word;
  } bank_word_t;

  logic clk = 1'b0;
  logic rst;

  pabu_in_if  bank();
  pabu_out_if result();

  packed_adc_bank_unpacker dut (
    .clk(clk),
    .rst(rst),
    .bank(bank),
    .result(result)
  );

  bank_word_t pending_words[$];
  res_t       expected_results[$];
  bank_word_t next_word;
  res_t       got;
  res_t       want;

  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int results_seen = 0;
  int errors = 0;
  bit mark_drain = 1'b0;
  bit fast_mode = 1'b0;

  // Shadow of the unpacker's bank tracking.
  logic [POS_W-1:0]   next_pos = '0;
  logic [BLOCK_W-1:0] blocks_total = '0;
  logic [BLOCK_W-1:0] block_at = '0;
  logic [SIB_W-1:0]   slot = '0;
  logic [LB_W-1:0]    spare_bits = '0;
  logic [LC_W-1:0]    spare_count = '0;
  logic [EID_W-1:0]   bank_event_id = '0;

  always #2 clk = ~clk;

  task automatic unpack_word(input logic [WORD_W-1:0] w, input logic [BW_W-1:0] bw,
                             input logic first);
    logic [POS_W-1:0] pos;
    logic [47:0]      acc;
    int               total;
    int               half;
    int               grp;
    int               in_grp;
    int               n;
    int               nb;
    int               i;
    res_t             r;
    res_t             made [3];
    n = 0;
    if (first) begin
      next_pos = '0;
      blocks_total = '0;
      block_at = '0;
      slot = '0;
      spare_bits = '0;
      spare_count = '0;
      bank_event_id = '0;
      if (bw >= HEADER_WORDS) begin
        nb = (int'(bw) - HEADER_WORDS) / 9;
        blocks_total = BLOCK_W'((nb > MAX_BLOCKS) ? MAX_BLOCKS : nb);
      end
    end
    pos = next_pos;
    if (next_pos != POS_LIMIT) next_pos = next_pos + 1'b1;
    if (pos == POS_EVENT_ID) begin
      bank_event_id = w[EID_W-1:0];
    end else if (pos == POS_TIME_TAG) begin
      if (bw >= HEADER_WORDS) begin
        r = '0;
        r.kind = KIND_HEADER;
        r.event_id = bank_event_id;
        r.time_tag = w;
        r.size_warning = ((int'(bw) - HEADER_WORDS) % 9) != 0;
        made[n] = r;
        n++;
      end
    end else if (pos >= POS_DATA && pos != POS_LIMIT && block_at < blocks_total) begin
      // Bits left from the previous word sit below the new word.
      acc = 48'(spare_bits) | (48'(w) << spare_count);
      total = WORD_W + int'(spare_count);
      half = int'(blocks_total) / 2;
      while (total >= SMP_W && n < 3) begin
        grp = (int'(block_at) >= half) ? 1 : 0;
        in_grp = int'(block_at) - grp * half;
        r = '0;
        r.kind = KIND_SAMPLE;
        r.event_id = bank_event_id;
        r.channel = CH_W'(grp * 8 + int'(slot) / 3);
        r.sample_index = IDX_W'(in_grp * 3 + int'(slot) % 3);
        r.sample = acc[SMP_W-1:0];
        made[n] = r;
        n++;
        acc = acc >> SMP_W;
        total -= SMP_W;
        slot = slot + 1'b1;
        if (slot >= BLOCK_SAMPLES) begin
          slot = '0;
          block_at = block_at + 1'b1;
        end
      end
      spare_count = LC_W'(total);
      spare_bits = acc[LB_W-1:0];
    end
    for (i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      expected_results = {expected_results, made[i]};
    end
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("kind=%0d eid=%03h tag=%08h warn=%0d ch=%0d idx=%0d smp=%03h last=%0d",
                     r.kind, r.event_id, r.time_tag, r.size_warning, r.channel,
                     r.sample_index, r.sample, r.last);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r == 1) return 32'h0000_0000;
    return $urandom();
  endfunction

  task automatic add_word(input logic [WORD_W-1:0] w, input int bw, input bit first);
    bank_word_t item;
    item.wait_drain = mark_drain;
    item.fast = fast_mode;
    item.first_word = first;
    item.bank_words = BW_W'(bw);
    item.word = w;
    mark_drain = 1'b0;
    pending_words = {pending_words, item};
  endtask

  // Queues a bank of len words and reports how many of them carry header or sample data.
  task automatic add_bank(input int bw, input int len, output int useful);
    int nb;
    int tag_bw;
    int i;
    nb = (bw >= HEADER_WORDS) ? (bw - HEADER_WORDS) / 9 : 0;
    if (nb > MAX_BLOCKS) nb = MAX_BLOCKS;
    tag_bw = bw;
    // Now and then the time tag word disagrees with the rest of the bank about its length.
    if ($urandom_range(0, 9) == 0)
      tag_bw = $urandom_range(0, 1) ? $urandom_range(0, HEADER_WORDS - 1) : $urandom_range(0, 9220);
    for (i = 0; i < len; i++)
      add_word(pick_word(), (i == 3) ? tag_bw : bw, i == 0);
    useful = (len < HEADER_WORDS + 9 * nb) ? len : HEADER_WORDS + 9 * nb;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bank.valid <= 1'b0;
      bank.word <= '0;
      bank.bank_words <= '0;
      bank.first_word <= 1'b0;
    end else begin
      if (bank.valid && bank.ready)
        unpack_word(bank.word, bank.bank_words, bank.first_word);
      if (!bank.valid || bank.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          bank.valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].wait_drain || expected_results.size() == 0)) begin
          next_word = pending_words.pop_front();
          bank.valid <= 1'b1;
          bank.word <= next_word.word;
          bank.bank_words <= next_word.bank_words;
          bank.first_word <= next_word.first_word;
          send_gap = next_word.fast ? 0 : idle_len(send_calm);
        end else begin
          bank.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        got = {result.kind, result.event_id, result.time_tag, result.size_warning,
               result.channel, result.sample_index, result.sample, result.last};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d: %s", results_seen, describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.event_id !== want.event_id ||
              got.time_tag !== want.time_tag || got.size_warning !== want.size_warning ||
              got.channel !== want.channel || got.sample_index !== want.sample_index ||
              got.sample !== want.sample || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: expected %s, got %s", results_seen,
                       describe(want), describe(got));
          end
        end
        // One long hold-off lets the result buffer fill and back up into the input.
        if (results_seen == 80 && !hold_done) begin
          hold_left = 300;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        recv_gap = idle_len(recv_calm);
      end
    end
  end

  initial begin
    int useful;
    int filled;
    int pick;
    int nb;
    int bw;
    int len;
    int i;
    rst = 1'b1;

    // Words before any bank start count from position zero, as a bank with no sample blocks.
    add_word(32'h1234_5678, 0, 1'b0);
    add_word(32'hFFFF_FFFF, 9220, 1'b0);
    add_word(32'hFFFF_FFFF, 13, 1'b0);
    add_word(32'hFFFF_FFFF, 13, 1'b0);
    add_word(32'h0000_0000, 13, 1'b0);
    add_word(32'hFFFF_FFFF, 13, 1'b0);
    // A single block is an odd count, so it belongs to channels 8 to 15.
    add_word(pick_word(), 13, 1'b1);
    add_word(pick_word(), 13, 1'b0);
    add_word(32'h0000_0000, 13, 1'b0);
    add_word(32'h0000_0000, 13, 1'b0);
    add_word(32'hFFFF_FFFF, 13, 1'b0);
    add_word(32'h0000_0000, 13, 1'b0);
    add_word(32'hA5A5_A5A5, 13, 1'b0);
    for (i = 0; i < 6; i++) add_word(pick_word(), 13, 1'b0);
    // A bank shorter than its header gives no header word.
    for (i = 0; i < 4; i++) add_word(pick_word(), 3, i == 0);
    add_word(pick_word(), 0, 1'b1);

    filled = 0;
    mark_drain = 1'b1;
    while (filled < 75) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        nb = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        bw = HEADER_WORDS + 9 * nb + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
        len = bw;
        pick = $urandom_range(0, 9);
        if (pick < 2) len = bw + $urandom_range(1, 6);
        else if (pick < 4) len = $urandom_range(1, bw);
        add_bank(bw, len, useful);
      end else if (pick < 85) begin
        add_bank($urandom_range(HEADER_WORDS, 9220), $urandom_range(4, 30), useful);
      end else if (pick < 93) begin
        add_bank($urandom_range(0, HEADER_WORDS - 1), $urandom_range(1, 6), useful);
      end else begin
        // Stray words without a bank start carry on from wherever the last bank stopped.
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) add_word(pick_word(), $urandom_range(0, 9220), 1'b0);
        useful = 0;
      end
      filled += useful;
    end

    // Above the block limit the count clamps, so the first group covers blocks 0 to 511.
    mark_drain = 1'b1;
    fast_mode = 1'b1;
    add_bank(16383, HEADER_WORDS + 9, useful);
    fast_mode = 1'b0;
    add_bank(HEADER_WORDS + 18, HEADER_WORDS + 18, useful);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || bank.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pabu_pkg.sv
rtl/pabu_if.sv
rtl/pabu_unpack.sv
rtl/packed_adc_bank_unpacker.sv
tb/sv/packed_adc_bank_unpacker_tb.sv
